[rtl/core/afa_pkg.sv]
// Shared types and constants for the ADC frame averager.
package afa_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 19;
   localparam int SUM_W   = 33;
   localparam int AVG_W   = 16;
   localparam int NUM_W   = 12;
   localparam int DEN_W   = AVG_W + NUM_W;
   localparam int PROD_W  = SUM_W + NUM_W;
   localparam int DVD_W   = PROD_W + FRACTION_BITS;
   localparam int STEP_W  = $clog2(DVD_W);
   localparam int LEVEL_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [NUM_W-1:0]   CH1_NUM   = NUM_W'(2511);
   localparam logic [NUM_W-1:0]   CH2_NUM   = NUM_W'(2506);
   localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(DVD_W - 1);

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_ONE  = 2'd1,
      MODE_TWO  = 2'd2,
      MODE_BOTH = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_CHANNEL_MODE  = 1'b0,
      CSR_AVERAGE_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[rtl/core/adc_frame_averager.sv]
// ADC frame averager: byte accumulation and a bit-serial scaling divider.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_data_byte, req_last_byte
//   rsp       out         rsp_valid/rsp_stall   levels of both channels, sync error
//   csr       in          csr_wr_en             csr_index, csr_wdata
//
// A byte that is not the last of its frame leaves the block idle, ready for the next byte.
// After the last byte the block stalls requests while it checks the frame and scales
// each selected channel (none, one or two); each scaling pass is a multiply state and then
// a shared restoring divider, one quotient bit a cycle.
// A finished result waits in the output register; the next frame's bytes, its last
// byte included, are taken and scaled meanwhile, and requests then stay stalled
// until the output register is free.
// Reset is synchronous and restores channel mode one and average count one.
module adc_frame_averager
   import afa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_last_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LEVEL_W-1:0]   rsp_channel_one_level,
   output logic [LEVEL_W-1:0]   rsp_channel_two_level,
   output logic                 rsp_sync_error,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [AVG_W-1:0]     csr_wdata
);

   state_type              state_ff, state_in;
   mode_type               mode_ff;
   logic [AVG_W-1:0]       avg_ff;

   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [BYTE_W-1:0]      hold_ff, hold_in;
   logic [SUM_W-1:0]       first_ff, first_in;
   logic [SUM_W-1:0]       second_ff, second_in;

   logic [DEN_W-1:0]       den_ff, den_in;
   logic                   pass_ff, pass_in;
   logic [DVD_W-1:0]       dvd_ff, dvd_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [LEVEL_W-1:0]     quo_ff, quo_in;
   logic                   ovf_ff, ovf_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [LEVEL_W-1:0]     lvl1_ff, lvl1_in;
   logic [LEVEL_W-1:0]     lvl2_ff, lvl2_in;
   logic                   err_ff, err_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]     rsp_one_ff, rsp_one_in;
   logic [LEVEL_W-1:0]     rsp_two_ff, rsp_two_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   req_take;
   logic [2*BYTE_W-1:0]    word;
   logic                   frame_err;
   logic [SUM_W-1:0]       sum_one, sum_two, sum_both, total;
   logic [NUM_W-1:0]       num;
   logic [PROD_W-1:0]      prod;
   logic [DEN_W:0]         trial;
   logic                   trial_ge;
   logic [LEVEL_W-1:0]     quo_next;
   logic                   ovf_next;
   logic [LEVEL_W-1:0]     level;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign word      = {req_data_byte, hold_ff};

   assign frame_err = (avg_ff == '0) ||
      !((count_ff == COUNT_W'({avg_ff, 1'b0})) || (count_ff == COUNT_W'({avg_ff, 2'b00})));

   assign sum_one  = count_ff[1] ? first_ff : second_ff;
   assign sum_two  = count_ff[1] ? second_ff : first_ff;
   assign sum_both = sum_one + sum_two;
   assign total    = (mode_ff == MODE_BOTH) ? (pass_ff ? sum_two : sum_one) : sum_both;
   assign num      = pass_ff ? CH2_NUM : CH1_NUM;
   assign prod     = PROD_W'(total) * PROD_W'(num);

   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});
   assign quo_next = {quo_ff[LEVEL_W-2:0], trial_ge};
   assign ovf_next = ovf_ff | quo_ff[LEVEL_W-1];
   assign level    = ovf_next ? {LEVEL_W{1'b1}} : quo_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ONE;
         avg_ff  <= AVG_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHANNEL_MODE:  mode_ff <= mode_type'(csr_wdata[1:0]);
            CSR_AVERAGE_COUNT: avg_ff  <= csr_wdata;
            default:           avg_ff  <= avg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hold_ff      <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hold_ff      <= hold_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff     <= den_in;
      pass_ff    <= pass_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
      step_ff    <= step_in;
      lvl1_ff    <= lvl1_in;
      lvl2_ff    <= lvl2_in;
      err_ff     <= err_in;
      rsp_one_ff <= rsp_one_in;
      rsp_two_ff <= rsp_two_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hold_in      = hold_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      den_in       = den_ff;
      pass_in      = pass_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      lvl1_in      = lvl1_ff;
      lvl2_in      = lvl2_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_one_in   = rsp_one_ff;
      rsp_two_in   = rsp_two_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (count_ff != COUNT_MAX) begin
                  if (!count_ff[0]) begin
                     hold_in = req_data_byte;
                  end else if (!count_ff[1]) begin
                     first_in = first_ff + SUM_W'(word);
                  end else begin
                     second_in = second_ff + SUM_W'(word);
                  end
                  count_in = count_ff + COUNT_W'(1);
               end
               if (req_last_byte) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            err_in  = frame_err;
            lvl1_in = '0;
            lvl2_in = '0;
            den_in  = {avg_ff, {NUM_W{1'b0}}} - DEN_W'(avg_ff);
            pass_in = (mode_ff == MODE_TWO);
            if (frame_err || mode_ff == MODE_NONE) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            dvd_in   = {prod, {FRACTION_BITS{1'b0}}};
            rem_in   = '0;
            quo_in   = '0;
            ovf_in   = 1'b0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
            dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
            quo_in  = quo_next;
            ovf_in  = ovf_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               if (pass_ff) begin
                  lvl2_in = level;
               end else begin
                  lvl1_in = level;
               end
               if (mode_ff == MODE_BOTH && !pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_one_in   = lvl1_ff;
               rsp_two_in   = lvl2_ff;
               rsp_err_in   = err_ff;
               count_in     = '0;
               hold_in      = '0;
               first_in     = '0;
               second_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_channel_one_level = rsp_one_ff;
   assign rsp_channel_two_level = rsp_two_ff;
   assign rsp_sync_error        = rsp_err_ff;

   a_err_zero_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_error |-> (rsp_channel_one_level == '0) &&
      (rsp_channel_two_level == '0))
      else $error("sync error response carries nonzero levels");

   a_mid_frame_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_last_byte && !rsp_valid |=> !rsp_valid)
      else $error("response appeared after a request that was not the last byte");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < den_ff)
      else $error("divider remainder reached the divisor");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> step_ff <= STEP_LAST)
      else $error("divider step counter ran past the last step");

endmodule
